// File: rtl/dfl_pkg.sv
// ----------------------------------------------------------------------------
// dfl_pkg
// Shared types, codes and widths for the descriptor free list allocator.
// ----------------------------------------------------------------------------
package dfl_pkg;

  localparam int CAPACITY  = 1024;
  localparam int HANDLE_W  = 64;
  localparam int STRIDE_W  = 16;
  localparam int SCOUNT_W  = 11;
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int QUOT_W    = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INACTIVE   = 3'd1,
    ST_BAD_HANDLE = 3'd2,
    ST_MISMATCH   = 3'd3,
    ST_RANGE      = 3'd4,
    ST_ALREADY    = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPU_BASE    = 3'd0,
    CFG_GPU_BASE    = 3'd1,
    CFG_SLOT_STRIDE = 3'd2,
    CFG_SLOT_COUNT  = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic    load_in;
    logic    pop;
    logic    div_start;
    logic    init;
    logic    clear;
    logic    fill_step;
    logic    mul;
    logic    add;
    logic    push;
    logic    scan_start;
    logic    scan_step;
    logic    res_load;
    status_t res_code;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    active;
    logic    count_zero;
    logic    hs_zero;
    logic    stride_zero;
    logic    below_base;
    logic    div_busy;
    logic    mismatch;
    logic    out_of_range;
    logic    full;
    logic    fill_last;
    logic    scan_last;
    logic    hit;
    logic    out_free;
  } sts_t;

endpackage

// File: rtl/dfl_ram.sv
// ----------------------------------------------------------------------------
// dfl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module dfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/dfl_div.sv
// ----------------------------------------------------------------------------
// dfl_div
// Restoring divider, one quotient bit per cycle; yields the low quotient bits.
// ----------------------------------------------------------------------------
module dfl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dfl_pkg::HANDLE_W-1:0]  dividend,
  input  logic [dfl_pkg::STRIDE_W-1:0]  divisor,
  output logic                          busy,
  output logic [dfl_pkg::QUOT_W-1:0]    quotient
);

  localparam int W   = dfl_pkg::HANDLE_W;
  localparam int DW  = dfl_pkg::STRIDE_W;
  localparam int CW  = $clog2(W);

  logic [CW-1:0] step;
  logic [W-1:0]  quo;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  assign rem_sh  = {rem, quo[W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + CW'(1);
      if (step == CW'(W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[W-2:0], ge};
      rem <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign quotient = quo[dfl_pkg::QUOT_W-1:0];

endmodule

// File: rtl/dfl_ctrl.sv
// ----------------------------------------------------------------------------
// dfl_ctrl
// Sequencer for allocate, free, init and clear requests.
// ----------------------------------------------------------------------------
module dfl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dfl_pkg::sts_t sts,
  output dfl_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_DECODE    = 10'b0000000010,
    S_ALLOC_MUL = 10'b0000000100,
    S_ALLOC_ADD = 10'b0000001000,
    S_FREE_DIV  = 10'b0000010000,
    S_FREE_CHK  = 10'b0000100000,
    S_SCAN      = 10'b0001000000,
    S_SCAN_TAIL = 10'b0010000000,
    S_FILL      = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.res_code = dfl_pkg::ST_OK;
    state_next   = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.op)
          dfl_pkg::OP_ALLOC: begin
            if (!sts.active || sts.count_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_code = dfl_pkg::ST_INACTIVE;
              state_next   = S_DONE;
            end else begin
              cmd.pop    = 1'b1;
              state_next = S_ALLOC_MUL;
            end
          end
          dfl_pkg::OP_FREE: begin
            if (!sts.active) begin
              cmd.res_load = 1'b1;
              cmd.res_code = dfl_pkg::ST_INACTIVE;
              state_next   = S_DONE;
            end else if (sts.stride_zero || sts.below_base) begin
              cmd.res_load = 1'b1;
              cmd.res_code = dfl_pkg::ST_BAD_HANDLE;
              state_next   = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_FREE_DIV;
            end
          end
          dfl_pkg::OP_INIT: begin
            cmd.init     = 1'b1;
            cmd.res_load = 1'b1;
            state_next   = sts.hs_zero ? S_DONE : S_FILL;
          end
          dfl_pkg::OP_CLEAR: begin
            cmd.clear    = 1'b1;
            cmd.res_load = 1'b1;
            state_next   = S_DONE;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_ALLOC_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ALLOC_ADD;
      end
      S_ALLOC_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_DONE;
      end
      S_FREE_DIV: begin
        if (!sts.div_busy) begin
          state_next = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        if (sts.mismatch) begin
          cmd.res_load = 1'b1;
          cmd.res_code = dfl_pkg::ST_MISMATCH;
          state_next   = S_DONE;
        end else if (sts.out_of_range) begin
          cmd.res_load = 1'b1;
          cmd.res_code = dfl_pkg::ST_RANGE;
          state_next   = S_DONE;
        end else if (sts.full) begin
          cmd.res_load = 1'b1;
          cmd.res_code = dfl_pkg::ST_ALREADY;
          state_next   = S_DONE;
        end else if (sts.count_zero) begin
          cmd.push     = 1'b1;
          cmd.res_load = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: begin
        cmd.res_load = 1'b1;
        if (sts.hit) begin
          cmd.res_code = dfl_pkg::ST_ALREADY;
        end else begin
          cmd.push = 1'b1;
        end
        state_next = S_DONE;
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/dfl_dp.sv
// ----------------------------------------------------------------------------
// dfl_dp
// Datapath: config registers, free stack, dividers, handle arithmetic and
// the output register.
// ----------------------------------------------------------------------------
module dfl_dp #(
  parameter int CAPACITY = dfl_pkg::CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [dfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfl_pkg::HANDLE_W-1:0]   cfg_data,
  input  logic [dfl_pkg::OPCODE_W-1:0]   opcode,
  input  logic [dfl_pkg::HANDLE_W-1:0]   cpu_handle_in,
  input  logic [dfl_pkg::HANDLE_W-1:0]   gpu_handle_in,
  input  dfl_pkg::cmd_t                  cmd,
  output dfl_pkg::sts_t                  sts,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [dfl_pkg::STATUS_W-1:0]   status,
  output logic [dfl_pkg::HANDLE_W-1:0]   cpu_handle_out,
  output logic [dfl_pkg::HANDLE_W-1:0]   gpu_handle_out
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int HW     = dfl_pkg::HANDLE_W;
  localparam int SW     = dfl_pkg::STRIDE_W;
  localparam int PROD_W = IDX_W + SW;
  localparam int QW     = dfl_pkg::QUOT_W;

  logic [dfl_pkg::OPCODE_W-1:0] op_q;
  logic [HW-1:0]                cin_q;
  logic [HW-1:0]                gin_q;

  logic [HW-1:0]                cpu_base;
  logic [HW-1:0]                gpu_base;
  logic [SW-1:0]                slot_stride;
  logic [dfl_pkg::SCOUNT_W-1:0] slot_count;

  logic [CNT_W-1:0] free_count;
  logic             heap_active;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] hs;
  logic [CNT_W-1:0] cnt_dec;
  logic [CNT_W-1:0] fill_val;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_rdata;

  logic          cpu_busy;
  logic          gpu_busy;
  logic [QW-1:0] q_cpu;
  logic [QW-1:0] q_gpu;

  logic [PROD_W-1:0] prod;
  logic              scan_valid;
  logic              hit;
  logic              match;

  dfl_pkg::status_t res_status;
  logic [HW-1:0]    res_cpu;
  logic [HW-1:0]    res_gpu;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_base    <= '0;
      gpu_base    <= '0;
      slot_stride <= '0;
      slot_count  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        dfl_pkg::CFG_CPU_BASE:    cpu_base    <= cfg_data;
        dfl_pkg::CFG_GPU_BASE:    gpu_base    <= cfg_data;
        dfl_pkg::CFG_SLOT_STRIDE: slot_stride <= cfg_data[SW-1:0];
        dfl_pkg::CFG_SLOT_COUNT:  slot_count  <= cfg_data[dfl_pkg::SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= opcode;
      cin_q <= cpu_handle_in;
      gin_q <= gpu_handle_in;
    end
  end

  assign hs = (32'(slot_count) < 32'(CAPACITY)) ? CNT_W'(slot_count) : CNT_W'(CAPACITY);
  assign cnt_dec  = free_count - CNT_W'(1);
  assign fill_val = hs - CNT_W'(1) - ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count  <= '0;
      heap_active <= 1'b0;
    end else if (cmd.clear) begin
      free_count  <= '0;
      heap_active <= 1'b0;
    end else if (cmd.init) begin
      free_count  <= hs;
      heap_active <= 1'b1;
    end else if (cmd.pop) begin
      free_count <= cnt_dec;
    end else if (cmd.push) begin
      free_count <= free_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init || cmd.scan_start) begin
      ptr <= '0;
    end else if (cmd.fill_step || cmd.scan_step) begin
      ptr <= ptr + CNT_W'(1);
    end
  end

  // free stack
  assign ram_we    = cmd.fill_step | cmd.push;
  assign ram_waddr = cmd.fill_step ? ptr[IDX_W-1:0] : free_count[IDX_W-1:0];
  assign ram_wdata = cmd.fill_step ? fill_val[IDX_W-1:0] : q_cpu[IDX_W-1:0];
  assign ram_raddr = cmd.pop ? cnt_dec[IDX_W-1:0] : ptr[IDX_W-1:0];

  dfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CAPACITY)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handle to index
  dfl_div u_div_cpu (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cin_q - cpu_base),
    .divisor  (slot_stride),
    .busy     (cpu_busy),
    .quotient (q_cpu)
  );

  dfl_div u_div_gpu (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (gin_q - gpu_base),
    .divisor  (slot_stride),
    .busy     (gpu_busy),
    .quotient (q_gpu)
  );

  // duplicate search
  assign match = (ram_rdata == q_cpu[IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_valid <= 1'b0;
    end else begin
      scan_valid <= cmd.scan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      hit <= 1'b0;
    end else if (scan_valid && match) begin
      hit <= 1'b1;
    end
  end

  // index to handle
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod <= PROD_W'(ram_rdata) * PROD_W'(slot_stride);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      res_status <= dfl_pkg::ST_OK;
      res_cpu    <= cpu_base + HW'(prod);
      res_gpu    <= gpu_base + HW'(prod);
    end else if (cmd.res_load) begin
      res_status <= cmd.res_code;
      res_cpu    <= '0;
      res_gpu    <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status         <= res_status;
      cpu_handle_out <= res_cpu;
      gpu_handle_out <= res_gpu;
    end
  end

  always_comb begin
    sts              = '0;
    sts.op           = dfl_pkg::opcode_t'(op_q);
    sts.active       = heap_active;
    sts.count_zero   = (free_count == '0);
    sts.hs_zero      = (hs == '0);
    sts.stride_zero  = (slot_stride == '0);
    sts.below_base   = (cin_q < cpu_base) || (gin_q < gpu_base);
    sts.div_busy     = cpu_busy | gpu_busy;
    sts.mismatch     = (q_cpu != q_gpu);
    sts.out_of_range = (q_cpu >= QW'(hs));
    sts.full         = (free_count == CNT_W'(CAPACITY));
    sts.fill_last    = (ptr == hs - CNT_W'(1));
    sts.scan_last    = (ptr == cnt_dec);
    sts.hit          = hit | (scan_valid & match);
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

// File: rtl/descriptor_free_list_allocator.sv
// ----------------------------------------------------------------------------
// descriptor_free_list_allocator
// LIFO free list of descriptor slot indices with handle conversion.
// Steps per request: clear and early rejects load the result directly,
// allocate pops an index, then multiplies and adds, init fills one stack entry
// per heap slot, and free runs the divide, then, when the duplicate search runs,
// one stack read per entry on the single RAM read port; one request at a time,
// the next one taken once the result sits in the output register.
// Synchronous reset empties the list and deactivates the heap; stack RAM is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module descriptor_free_list_allocator #(
  parameter int CAPACITY = dfl_pkg::CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dfl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dfl_pkg::HANDLE_W-1:0]   cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dfl_pkg::OPCODE_W-1:0]   opcode,
  input  logic [dfl_pkg::HANDLE_W-1:0]   cpu_handle_in,
  input  logic [dfl_pkg::HANDLE_W-1:0]   gpu_handle_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [dfl_pkg::STATUS_W-1:0]   status,
  output logic [dfl_pkg::HANDLE_W-1:0]   cpu_handle_out,
  output logic [dfl_pkg::HANDLE_W-1:0]   gpu_handle_out
);

  dfl_pkg::cmd_t cmd;
  dfl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dfl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .cpu_handle_in  (cpu_handle_in),
    .gpu_handle_in  (gpu_handle_in),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .status         (status),
    .cpu_handle_out (cpu_handle_out),
    .gpu_handle_out (gpu_handle_out)
  );

endmodule

// File: rtl/dfl_checker.sv
// ----------------------------------------------------------------------------
// dfl_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dfl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [dfl_pkg::STATUS_W-1:0]  status,
  input logic [dfl_pkg::HANDLE_W-1:0]  cpu_handle_out,
  input logic [dfl_pkg::HANDLE_W-1:0]  gpu_handle_out
);

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= dfl_pkg::ST_ALREADY)
    else $error("undefined status code");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != dfl_pkg::ST_OK |->
      cpu_handle_out == '0 && gpu_handle_out == '0)
    else $error("handles not zero on failed request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=>
      out_valid && $stable(status) && $stable(cpu_handle_out) && $stable(gpu_handle_out))
    else $error("result changed while stalled");

endmodule

bind descriptor_free_list_allocator dfl_checker u_dfl_checker (.*);
